// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked concurrent assertions with the reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that holds at every clock edge out of reset.
`define CTH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// A consequence that holds in the same cycle as its antecedent.
`define CTH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// A consequence that holds in the cycle after its antecedent.
`define CTH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/cth_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cth_pkg
// Types and constants shared by the chained tag hash multimap.
// ----------------------------------------------------------------------------
package cth_pkg;

  // Table geometry. The bucket count is a power of two, so the bucket of a
  // tag is its low bits.
  localparam int BUCKETS  = 4096;
  localparam int CAPACITY = 1024;
  localparam int BKT_W    = $clog2(BUCKETS);
  localparam int ENT_AW   = $clog2(CAPACITY);
  localparam int CNT_W    = ENT_AW + 1;

  // Field widths.
  localparam int CMD_W  = 3;
  localparam int TAG_W  = 32;
  localparam int VAL_W  = 32;
  localparam int IDX_W  = 11;
  localparam int STAT_W = 2;

  localparam logic [BKT_W-1:0] BKT_LAST = BKT_W'(BUCKETS - 1);
  localparam logic [IDX_W-1:0] IDX_NONE = '1;
  localparam logic [TAG_W-1:0] TAG_NONE = '1;

  // Command codes.
  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT     = 3'd0,
    CMD_CHECK      = 3'd1,
    CMD_FIND_FIRST = 3'd2,
    CMD_FIND_NEXT  = 3'd3,
    CMD_READ       = 3'd4,
    CMD_CLEAR      = 3'd5
  } cmd_e;

  // Status codes.
  localparam logic [STAT_W-1:0] STAT_DONE   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_REJECT = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL   = 2'd2;

  // One word of the entry store.
  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [VAL_W-1:0] value;
    logic [IDX_W-1:0] link;
  } entry_t;

  // Access request to the bucket head memory.
  typedef struct packed {
    logic             we;
    logic [BKT_W-1:0] waddr;
    logic [IDX_W-1:0] wdata;
    logic             re;
    logic [BKT_W-1:0] raddr;
  } head_req_t;

  // Access request to the entry store.
  typedef struct packed {
    logic              we;
    logic [ENT_AW-1:0] waddr;
    entry_t            wdata;
    logic              re;
    logic [ENT_AW-1:0] raddr;
  } entry_req_t;

endpackage

// ===== sv/cth_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cth_if
// Valid/ready channels for commands and results of the hash multimap.
// ----------------------------------------------------------------------------

// Command channel.
interface cth_in_if import cth_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        command;
  logic signed [TAG_W-1:0] tag;
  logic [VAL_W-1:0]        value;
  logic signed [IDX_W-1:0] index;

  modport source (output valid, command, tag, value, index, input ready);
  modport sink (input valid, command, tag, value, index, output ready);
endinterface

// Result channel.
interface cth_out_if import cth_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [STAT_W-1:0]       status;
  logic                    found;
  logic signed [IDX_W-1:0] entry_index;
  logic signed [TAG_W-1:0] entry_tag;
  logic [VAL_W-1:0]        entry_value;

  modport source (output valid, status, found, entry_index, entry_tag, entry_value,
                  input ready);
  modport sink (input valid, status, found, entry_index, entry_tag, entry_value,
                output ready);
endinterface

// ===== sv/cth_head_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cth_head_mem
// Bucket head memory: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module cth_head_mem import cth_pkg::*; (
  input  logic             clk_i,
  input  head_req_t        req_i,
  output logic [IDX_W-1:0] rdata_o
);

  logic [IDX_W-1:0] mem [BUCKETS];
  logic [IDX_W-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/cth_entry_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cth_entry_mem
// Entry store holding tag, value and chain link of each entry.
// ----------------------------------------------------------------------------
module cth_entry_mem import cth_pkg::*; (
  input  logic       clk_i,
  input  entry_req_t req_i,
  output entry_t     rdata_o
);

  entry_t mem [CAPACITY];
  entry_t rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/chained_tag_hash_multimap.sv =====
`timescale 1ns / 1ps
// The chain walk visits one entry per cycle, bound by the entry store read port;
// an append writes the new entry, then links it to the old tail of a non-empty chain.
// One command at a time: the next beat is taken the cycle after the result is
// registered, while that result may still wait at the output.
// Reset: a pass clearing all 4096 bucket heads runs first; no beat is taken meanwhile.
// ----------------------------------------------------------------------------
// chained_tag_hash_multimap
// Hash multimap from 32-bit tags to value handles with chained buckets in
// an append-only entry store.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module chained_tag_hash_multimap import cth_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  cth_in_if.sink     in_i,
  cth_out_if.source  out_o
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_START,
    S_HEAD,
    S_NEXT,
    S_WALK,
    S_READ,
    S_APPEND,
    S_LINK,
    S_RESP
  } state_e;

  // An index names a written entry when it is not negative and below the count.
  function automatic logic idx_ok(input logic [IDX_W-1:0] i, input logic [CNT_W-1:0] n);
    return !i[IDX_W-1] && (CNT_W'(i) < n);
  endfunction

  state_e            state_q, state_d;
  logic [CMD_W-1:0]  cmd_q, cmd_d;
  logic [TAG_W-1:0]  tag_q, tag_d;
  logic [VAL_W-1:0]  val_q, val_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [IDX_W-1:0]  cur_q, cur_d;
  logic [CNT_W-1:0]  steps_q, steps_d;
  logic [IDX_W-1:0]  last_q, last_d;
  logic              last_vld_q, last_vld_d;
  entry_t            last_ent_q, last_ent_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [BKT_W-1:0]  clr_addr_q, clr_addr_d;
  logic              clr_resp_q, clr_resp_d;
  logic [STAT_W-1:0] res_status_q, res_status_d;
  logic              res_found_q, res_found_d;
  logic [IDX_W-1:0]  res_idx_q, res_idx_d;
  logic [TAG_W-1:0]  res_tag_q, res_tag_d;
  logic [VAL_W-1:0]  res_val_q, res_val_d;
  logic              out_valid_q, out_valid_d;
  logic [STAT_W-1:0] out_status_q, out_status_d;
  logic              out_found_q, out_found_d;
  logic [IDX_W-1:0]  out_idx_q, out_idx_d;
  logic [TAG_W-1:0]  out_tag_q, out_tag_d;
  logic [VAL_W-1:0]  out_val_q, out_val_d;

  head_req_t         head_req;
  logic [IDX_W-1:0]  head_rdata;
  entry_req_t        ent_req;
  entry_t            ent_rdata;

  logic              bad_tag;
  logic              bad_val;
  logic              by_value;
  logic              ent_match;
  logic [IDX_W-1:0]  walk_start;
  logic [CNT_W-1:0]  steps_inc;
  logic              miss;
  logic              append_done;

  cth_head_mem u_head_mem (
    .clk_i   (clk_i),
    .req_i   (head_req),
    .rdata_o (head_rdata)
  );

  cth_entry_mem u_entry_mem (
    .clk_i   (clk_i),
    .req_i   (ent_req),
    .rdata_o (ent_rdata)
  );

  // Argument checks and chain compare.
  assign bad_tag    = (tag_q == '0) || (tag_q == TAG_NONE);
  assign bad_val    = (val_q == '0);
  assign by_value   = (cmd_q == CMD_INSERT) || (cmd_q == CMD_CHECK);
  assign ent_match  = (ent_rdata.tag == tag_q) && (!by_value || (ent_rdata.value == val_q));
  assign walk_start = (state_q == S_NEXT) ? ent_rdata.link : head_rdata;
  assign steps_inc  = steps_q + CNT_W'(1);

  // Sequencer. Only one command is in flight, so a write to either memory
  // always lands before any read that could see it.
  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    tag_d        = tag_q;
    val_d        = val_q;
    idx_d        = idx_q;
    cur_d        = cur_q;
    steps_d      = steps_q;
    last_d       = last_q;
    last_vld_d   = last_vld_q;
    last_ent_d   = last_ent_q;
    count_d      = count_q;
    clr_addr_d   = clr_addr_q;
    clr_resp_d   = clr_resp_q;
    res_status_d = res_status_q;
    res_found_d  = res_found_q;
    res_idx_d    = res_idx_q;
    res_tag_d    = res_tag_q;
    res_val_d    = res_val_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_status_d = out_status_q;
    out_found_d  = out_found_q;
    out_idx_d    = out_idx_q;
    out_tag_d    = out_tag_q;
    out_val_d    = out_val_q;
    head_req     = '0;
    ent_req      = '0;
    miss         = 1'b0;
    append_done  = 1'b0;

    unique case (state_q) inside
      // Sweep every bucket head back to empty.
      S_CLEAR: begin
        head_req.we    = 1'b1;
        head_req.waddr = clr_addr_q;
        head_req.wdata = IDX_NONE;
        clr_addr_d     = clr_addr_q + BKT_W'(1);
        if (clr_addr_q == BKT_LAST) begin
          count_d = '0;
          state_d = clr_resp_q ? S_RESP : S_IDLE;
        end
      end

      // Take a command beat.
      S_IDLE: begin
        if (in_i.valid) begin
          cmd_d   = in_i.command;
          tag_d   = in_i.tag;
          val_d   = in_i.value;
          idx_d   = in_i.index;
          state_d = S_START;
        end
      end

      // Check arguments and issue the first memory read, or start a clear pass.
      S_START: begin
        res_status_d = STAT_DONE;
        res_found_d  = 1'b0;
        res_idx_d    = IDX_NONE;
        res_tag_d    = TAG_NONE;
        res_val_d    = '0;
        state_d      = S_RESP;
        unique case (cmd_q) inside
          CMD_INSERT, CMD_CHECK: begin
            if (bad_tag || bad_val) begin
              res_status_d = STAT_REJECT;
            end else begin
              head_req.re    = 1'b1;
              head_req.raddr = tag_q[BKT_W-1:0];
              state_d        = S_HEAD;
            end
          end
          CMD_FIND_FIRST: begin
            if (bad_tag) begin
              res_status_d = STAT_REJECT;
            end else begin
              head_req.re    = 1'b1;
              head_req.raddr = tag_q[BKT_W-1:0];
              state_d        = S_HEAD;
            end
          end
          CMD_FIND_NEXT: begin
            if (bad_tag) begin
              res_status_d = STAT_REJECT;
            end else if (idx_q == IDX_NONE) begin
              res_status_d = STAT_DONE;
            end else if (!idx_ok(idx_q, count_q)) begin
              res_status_d = STAT_REJECT;
            end else begin
              ent_req.re    = 1'b1;
              ent_req.raddr = idx_q[ENT_AW-1:0];
              state_d       = S_NEXT;
            end
          end
          CMD_READ: begin
            if (!idx_ok(idx_q, count_q)) begin
              res_status_d = STAT_REJECT;
            end else begin
              ent_req.re    = 1'b1;
              ent_req.raddr = idx_q[ENT_AW-1:0];
              state_d       = S_READ;
            end
          end
          CMD_CLEAR: begin
            clr_addr_d = '0;
            clr_resp_d = 1'b1;
            state_d    = S_CLEAR;
          end
          default: begin
            res_status_d = STAT_REJECT;
          end
        endcase
      end

      // Start of a chain: a bucket head or the link of a given entry.
      S_HEAD, S_NEXT: begin
        steps_d    = '0;
        last_vld_d = 1'b0;
        if (idx_ok(walk_start, count_q)) begin
          ent_req.re    = 1'b1;
          ent_req.raddr = walk_start[ENT_AW-1:0];
          cur_d         = walk_start;
          state_d       = S_WALK;
        end else begin
          miss = 1'b1;
        end
      end

      // Compare one chain entry and read the next one in the same cycle.
      S_WALK: begin
        if (ent_match) begin
          res_found_d = 1'b1;
          res_idx_d   = cur_q;
          state_d     = S_RESP;
        end else begin
          last_d     = cur_q;
          last_vld_d = 1'b1;
          last_ent_d = ent_rdata;
          steps_d    = steps_inc;
          if (idx_ok(ent_rdata.link, count_q) && (steps_inc < CNT_W'(CAPACITY))) begin
            ent_req.re    = 1'b1;
            ent_req.raddr = ent_rdata.link[ENT_AW-1:0];
            cur_d         = ent_rdata.link;
          end else begin
            miss = 1'b1;
          end
        end
      end

      S_READ: begin
        res_found_d = 1'b1;
        res_idx_d   = idx_q;
        res_tag_d   = ent_rdata.tag;
        res_val_d   = ent_rdata.value;
        state_d     = S_RESP;
      end

      // Write the new entry; an empty bucket gets it as its head.
      S_APPEND: begin
        ent_req.we         = 1'b1;
        ent_req.waddr      = count_q[ENT_AW-1:0];
        ent_req.wdata.tag  = tag_q;
        ent_req.wdata.value = val_q;
        ent_req.wdata.link = IDX_NONE;
        if (last_vld_q) begin
          state_d = S_LINK;
        end else begin
          head_req.we    = 1'b1;
          head_req.waddr = tag_q[BKT_W-1:0];
          head_req.wdata = IDX_W'(count_q);
          append_done    = 1'b1;
        end
      end

      // Hook the new entry onto the old tail of the chain.
      S_LINK: begin
        ent_req.we          = 1'b1;
        ent_req.waddr       = last_q[ENT_AW-1:0];
        ent_req.wdata.tag   = last_ent_q.tag;
        ent_req.wdata.value = last_ent_q.value;
        ent_req.wdata.link  = IDX_W'(count_q);
        append_done         = 1'b1;
      end

      // Move the result into the output register once it is free.
      S_RESP: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_found_d  = res_found_q;
          out_idx_d    = res_idx_q;
          out_tag_d    = res_tag_q;
          out_val_d    = res_val_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // End of a chain without a match.
    if (miss) begin
      if (cmd_q == CMD_INSERT) begin
        if (count_q >= CNT_W'(CAPACITY)) begin
          res_status_d = STAT_FULL;
          state_d      = S_RESP;
        end else begin
          state_d = S_APPEND;
        end
      end else begin
        state_d = S_RESP;
      end
    end

    // An append answers with the index it used.
    if (append_done) begin
      res_idx_d = IDX_W'(count_q);
      count_d   = count_q + CNT_W'(1);
      state_d   = S_RESP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      cmd_q        <= '0;
      tag_q        <= '0;
      val_q        <= '0;
      idx_q        <= '0;
      cur_q        <= '0;
      steps_q      <= '0;
      last_q       <= '0;
      last_vld_q   <= 1'b0;
      last_ent_q   <= '0;
      count_q      <= '0;
      clr_addr_q   <= '0;
      clr_resp_q   <= 1'b0;
      res_status_q <= '0;
      res_found_q  <= 1'b0;
      res_idx_q    <= '0;
      res_tag_q    <= '0;
      res_val_q    <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= '0;
      out_found_q  <= 1'b0;
      out_idx_q    <= '0;
      out_tag_q    <= '0;
      out_val_q    <= '0;
    end else begin
      state_q      <= state_d;
      cmd_q        <= cmd_d;
      tag_q        <= tag_d;
      val_q        <= val_d;
      idx_q        <= idx_d;
      cur_q        <= cur_d;
      steps_q      <= steps_d;
      last_q       <= last_d;
      last_vld_q   <= last_vld_d;
      last_ent_q   <= last_ent_d;
      count_q      <= count_d;
      clr_addr_q   <= clr_addr_d;
      clr_resp_q   <= clr_resp_d;
      res_status_q <= res_status_d;
      res_found_q  <= res_found_d;
      res_idx_q    <= res_idx_d;
      res_tag_q    <= res_tag_d;
      res_val_q    <= res_val_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_found_q  <= out_found_d;
      out_idx_q    <= out_idx_d;
      out_tag_q    <= out_tag_d;
      out_val_q    <= out_val_d;
    end
  end

  // Channel outputs.
  assign in_i.ready        = (state_q == S_IDLE);
  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_status_q;
  assign out_o.found       = out_found_q;
  assign out_o.entry_index = $signed(out_idx_q);
  assign out_o.entry_tag   = $signed(out_tag_q);
  assign out_o.entry_value = out_val_q;

  // Checks on the table bookkeeping.
  `CTH_ASSERT(a_count_bound, count_q <= CNT_W'(CAPACITY), "entry count above capacity")
  `CTH_ASSERT_IMP(a_walk_written, state_q == S_WALK, idx_ok(cur_q, count_q), "walk on unwritten entry")
  `CTH_ASSERT_IMP(a_append_room, state_q == S_APPEND, count_q < CNT_W'(CAPACITY), "append into full store")
  `CTH_ASSERT_IMP(a_link_tail, state_q == S_LINK, last_vld_q && idx_ok(last_q, count_q), "link without tail")
  `CTH_ASSERT_NXT(a_clear_done, (state_q == S_CLEAR) && (clr_addr_q == BKT_LAST), (count_q == '0) && (state_q != S_CLEAR), "clear pass did not finish")

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the chained tag hash multimap. A shadow copy of the
// table predicts the answer to every accepted command beat, and each answer
// beat is compared field by field, in order. After a short directed sequence,
// the stimulus runs a mixed phase with clears, then fills the entry store to
// capacity through long collision chains, and ends with the store full.
// ----------------------------------------------------------------------------

package cth_tb_pkg;
  import cth_pkg::*;

  // The two command codes that the block does not define.
  localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [TAG_W-1:0] tag;
    logic [VAL_W-1:0] value;
    logic [IDX_W-1:0] index;
  } mm_cmd_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              found;
    logic [IDX_W-1:0]  entry_index;
    logic [TAG_W-1:0]  entry_tag;
    logic [VAL_W-1:0]  entry_value;
  } mm_ans_t;

  // Shadow copy of the table and the answers still owed by the block.
  class multimap_shadow;
    logic [IDX_W-1:0] heads    [BUCKETS];
    logic [TAG_W-1:0] ent_tag  [CAPACITY];
    logic [VAL_W-1:0] ent_val  [CAPACITY];
    logic [IDX_W-1:0] ent_link [CAPACITY];
    int               fill;
    mm_ans_t          pending_answers [$];
    int               mismatches;
    int               commands_seen;
    int               answers_seen;
    int               stored;
    int               full_hits;
    int               rejects;
    int               clears;
    int               deepest_walk;

    function new();
      empty_table();
      mismatches    = 0;
      commands_seen = 0;
      answers_seen  = 0;
      stored        = 0;
      full_hits     = 0;
      rejects       = 0;
      clears        = 0;
      deepest_walk  = 0;
    endfunction

    function void empty_table();
      foreach (heads[k]) heads[k] = IDX_NONE;
      fill = 0;
    endfunction

    // An index names a stored entry only when it is non-negative and below the fill.
    function bit live(logic [IDX_W-1:0] i);
      return (i[IDX_W-1] == 1'b0) && (int'(i) < fill);
    endfunction

    // Follow a chain for a tag (and value when asked). The last entry passed
    // over is handed back so that an append knows where to link.
    function logic [IDX_W-1:0] walk(logic [IDX_W-1:0] start, logic [TAG_W-1:0] tag,
                                    bit by_value, logic [VAL_W-1:0] val,
                                    output logic [IDX_W-1:0] tail);
      logic [IDX_W-1:0] cur;
      int               steps;
      cur   = start;
      tail  = IDX_NONE;
      steps = 0;
      while (live(cur) && steps < CAPACITY) begin
        if (ent_tag[cur[ENT_AW-1:0]] == tag &&
            (!by_value || ent_val[cur[ENT_AW-1:0]] == val)) begin
          return cur;
        end
        tail = cur;
        cur  = ent_link[cur[ENT_AW-1:0]];
        steps++;
        if (steps > deepest_walk) deepest_walk = steps;
      end
      return IDX_NONE;
    endfunction

    // Apply one accepted command to the shadow table and queue its answer.
    function mm_ans_t apply_command(mm_cmd_t c);
      mm_ans_t           a;
      logic [BKT_W-1:0]  b;
      logic [IDX_W-1:0]  tail;
      logic [IDX_W-1:0]  hit;
      logic [ENT_AW-1:0] slot;
      bit                null_tag;
      a.status      = STAT_DONE;
      a.found       = 1'b0;
      a.entry_index = IDX_NONE;
      a.entry_tag   = TAG_NONE;
      a.entry_value = '0;
      b        = c.tag[BKT_W-1:0];
      null_tag = (c.tag == '0) || (c.tag == TAG_NONE);
      commands_seen++;
      case (c.command)
        CMD_INSERT: begin
          if (null_tag || c.value == '0) begin
            a.status = STAT_REJECT;
          end else begin
            hit = walk(heads[b], c.tag, 1'b1, c.value, tail);
            if (hit != IDX_NONE) begin
              a.found       = 1'b1;
              a.entry_index = hit;
            end else if (fill >= CAPACITY) begin
              a.status = STAT_FULL;
            end else begin
              slot           = ENT_AW'(fill);
              ent_tag[slot]  = c.tag;
              ent_val[slot]  = c.value;
              ent_link[slot] = IDX_NONE;
              if (tail == IDX_NONE) heads[b] = IDX_W'(fill);
              else ent_link[tail[ENT_AW-1:0]] = IDX_W'(fill);
              a.entry_index = IDX_W'(fill);
              fill++;
              stored++;
            end
          end
        end
        CMD_CHECK: begin
          if (null_tag || c.value == '0) begin
            a.status = STAT_REJECT;
          end else begin
            a.entry_index = walk(heads[b], c.tag, 1'b1, c.value, tail);
            a.found       = (a.entry_index != IDX_NONE);
          end
        end
        CMD_FIND_FIRST: begin
          if (null_tag) begin
            a.status = STAT_REJECT;
          end else begin
            a.entry_index = walk(heads[b], c.tag, 1'b0, '0, tail);
            a.found       = (a.entry_index != IDX_NONE);
          end
        end
        CMD_FIND_NEXT: begin
          // An index of none simply answers nothing found.
          if (null_tag) begin
            a.status = STAT_REJECT;
          end else if (c.index != IDX_NONE) begin
            if (!live(c.index)) begin
              a.status = STAT_REJECT;
            end else begin
              a.entry_index = walk(ent_link[c.index[ENT_AW-1:0]], c.tag, 1'b0, '0, tail);
              a.found       = (a.entry_index != IDX_NONE);
            end
          end
        end
        CMD_READ: begin
          if (!live(c.index)) begin
            a.status = STAT_REJECT;
          end else begin
            a.found       = 1'b1;
            a.entry_index = c.index;
            a.entry_tag   = ent_tag[c.index[ENT_AW-1:0]];
            a.entry_value = ent_val[c.index[ENT_AW-1:0]];
          end
        end
        CMD_CLEAR: begin
          empty_table();
          clears++;
        end
        default: a.status = STAT_REJECT;
      endcase
      if (a.status == STAT_REJECT) rejects++;
      if (a.status == STAT_FULL) full_hits++;
      pending_answers.push_back(a);
      return a;
    endfunction

    task report_mismatch(string what);
      $display("%t MISMATCH: %s", $realtime, what);
      mismatches++;
    endtask

    // Compare one answer beat against the oldest answer owed.
    task compare_answer(mm_ans_t got);
      mm_ans_t want;
      answers_seen++;
      if (pending_answers.size() == 0) begin
        report_mismatch($sformatf("answer %0d arrived with nothing outstanding",
                                  answers_seen));
      end else begin
        want = pending_answers.pop_front();
        if (got.status !== want.status)
          report_mismatch($sformatf("answer %0d status %0d, wanted %0d",
                                    answers_seen, got.status, want.status));
        if (got.found !== want.found)
          report_mismatch($sformatf("answer %0d found %0b, wanted %0b",
                                    answers_seen, got.found, want.found));
        if (got.entry_index !== want.entry_index)
          report_mismatch($sformatf("answer %0d entry_index %0d, wanted %0d", answers_seen,
                                    $signed(got.entry_index), $signed(want.entry_index)));
        if (got.entry_tag !== want.entry_tag)
          report_mismatch($sformatf("answer %0d entry_tag %h, wanted %h",
                                    answers_seen, got.entry_tag, want.entry_tag));
        if (got.entry_value !== want.entry_value)
          report_mismatch($sformatf("answer %0d entry_value %h, wanted %h",
                                    answers_seen, got.entry_value, want.entry_value));
      end
    endtask
  endclass

endpackage

module testbench;
  import cth_pkg::*;
  import cth_tb_pkg::*;

  localparam int IDLE_PCT      = 22;
  localparam int CALM_FIRST    = 600;
  localparam int CALM_LAST     = 800;
  localparam int HOLD_AT       = 300;
  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 64;
  localparam int MIXED_ITEMS   = 120;
  localparam int TAIL_ITEMS    = 40;
  localparam int POOL_SIZE     = 24;
  localparam int HI_W          = TAG_W - BKT_W;

  logic clk_i;
  logic rst_ni;

  cth_in_if  cmd_if ();
  cth_out_if ans_if ();

  multimap_shadow   shadow = new();
  int               sent = 0;
  int               idle_cycles = 0;
  logic [BKT_W-1:0] bucket_pool [POOL_SIZE];
  logic [TAG_W-1:0] chase_tag;
  logic [IDX_W-1:0] chase_idx;

  chained_tag_hash_multimap u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (ans_if)
  );

  // 50 MHz clock.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog: give up when no beat moves on either side for too long.
  always @(posedge clk_i) begin
    if ((cmd_if.valid && cmd_if.ready) || (ans_if.valid && ans_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%t Watchdog: no beat for %0d cycles, %0d answers outstanding",
               $realtime, idle_cycles, shadow.pending_answers.size());
      $display("chained_tag_hash_multimap test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Beats inside this window see no idling on either side.
  function automatic bit calm(int n);
    return n >= CALM_FIRST && n < CALM_LAST;
  endfunction

  // Answer side: random stalls, one long hold-off, and a check of every beat.
  initial begin : answer_sink
    int      taken;
    int      hold_left;
    mm_ans_t got;
    taken     = 0;
    hold_left = 0;
    forever begin
      if (hold_left > 0) begin
        ans_if.ready <= 1'b0;
        hold_left--;
      end else begin
        ans_if.ready <= calm(taken) || ($urandom_range(99) >= IDLE_PCT);
      end
      @(posedge clk_i);
      if (ans_if.valid && ans_if.ready) begin
        got.status      = ans_if.status;
        got.found       = ans_if.found;
        got.entry_index = ans_if.entry_index;
        got.entry_tag   = ans_if.entry_tag;
        got.entry_value = ans_if.entry_value;
        shadow.compare_answer(got);
        taken++;
        if (taken == HOLD_AT) hold_left = HOLD_CYCLES;
      end
    end
  end

  function automatic mm_cmd_t mk(logic [CMD_W-1:0] op, logic [TAG_W-1:0] tag,
                                 logic [VAL_W-1:0] val, logic [IDX_W-1:0] idx);
    mm_cmd_t c;
    c.command = op;
    c.tag     = tag;
    c.value   = val;
    c.index   = idx;
    return c;
  endfunction

  // Tags lean toward a few crowded buckets so that chains grow long.
  function automatic logic [TAG_W-1:0] pick_tag();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 15) return {HI_W'($urandom_range(63)), bucket_pool[0]};
    if (roll < 55)
      return {HI_W'($urandom_range(15)), bucket_pool[$urandom_range(POOL_SIZE - 1)]};
    if (roll < 75 && shadow.fill > 0)
      return shadow.ent_tag[ENT_AW'($urandom_range(shadow.fill - 1))];
    if (roll < 85) begin
      case ($urandom_range(6))
        0:       return '0;
        1:       return TAG_NONE;
        2:       return 32'h8000_0000;
        3:       return 32'h7fff_ffff;
        4:       return 32'h0000_0001;
        5:       return 32'hffff_fffe;
        default: return 32'h0000_1000;
      endcase
    end
    return $urandom();
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) return '0;
    if (roll < 70) return VAL_W'($urandom_range(6, 1));
    if (roll < 80) return '1;
    return $urandom();
  endfunction

  function automatic logic [IDX_W-1:0] pick_index();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 60 && shadow.fill > 0) return IDX_W'($urandom_range(shadow.fill - 1));
    if (roll < 70) return IDX_NONE;
    if (roll < 80) return IDX_W'(shadow.fill);
    return IDX_W'($urandom());
  endfunction

  // Any command; find next mostly continues the last successful search.
  function automatic mm_cmd_t mixed_command(bit clears_ok);
    mm_cmd_t     c;
    int unsigned roll;
    int unsigned pos;
    c    = mk(CMD_INSERT, pick_tag(), pick_value(), pick_index());
    roll = $urandom_range(99);
    if (roll < 34) begin
      c.command = CMD_INSERT;
    end else if (roll < 48) begin
      c.command = CMD_CHECK;
      if (shadow.fill > 0 && $urandom_range(1) == 1) begin
        pos     = $urandom_range(shadow.fill - 1);
        c.tag   = shadow.ent_tag[ENT_AW'(pos)];
        c.value = shadow.ent_val[ENT_AW'(pos)];
      end
    end else if (roll < 62) begin
      c.command = CMD_FIND_FIRST;
    end else if (roll < 78) begin
      c.command = CMD_FIND_NEXT;
      if (chase_idx != IDX_NONE && $urandom_range(3) != 0) begin
        c.tag   = chase_tag;
        c.index = chase_idx;
      end
    end else if (roll < 94) begin
      c.command = CMD_READ;
    end else if (roll < 97) begin
      c.command = ($urandom_range(1) == 1) ? CMD_SPARE_A : CMD_SPARE_B;
    end else begin
      c.command = clears_ok ? CMD_CLEAR : CMD_CHECK;
    end
    return c;
  endfunction

  // Mostly fresh inserts, 30 percent of them into one crowded bucket.
  function automatic mm_cmd_t fill_command();
    logic [BKT_W-1:0] b;
    if ($urandom_range(99) >= 85) return mixed_command(1'b0);
    b = ($urandom_range(99) < 30) ? bucket_pool[0] : bucket_pool[$urandom_range(POOL_SIZE - 1)];
    return mk(CMD_INSERT, {HI_W'($urandom()), b}, VAL_W'($urandom_range(6, 1)), pick_index());
  endfunction

  // Offer one command beat and wait until it is taken.
  task automatic issue(input mm_cmd_t c);
    mm_ans_t a;
    while (!calm(sent) && $urandom_range(99) < IDLE_PCT) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_if.valid   <= 1'b1;
    cmd_if.command <= c.command;
    cmd_if.tag     <= c.tag;
    cmd_if.value   <= c.value;
    cmd_if.index   <= c.index;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    a = shadow.apply_command(c);
    sent++;
    // Remember where a search stopped so that find next can pick it up.
    if (c.command == CMD_FIND_FIRST || c.command == CMD_FIND_NEXT) begin
      chase_tag = c.tag;
      chase_idx = a.found ? a.entry_index : IDX_NONE;
    end else if (c.command == CMD_CLEAR) begin
      chase_idx = IDX_NONE;
    end
  endtask

  // Stop offering until every owed answer has come back.
  task automatic pause_until_drained();
    cmd_if.valid <= 1'b0;
    do @(posedge clk_i); while (shadow.pending_answers.size() != 0);
  endtask

  // Directed sequence: chains in one bucket, duplicates, null arguments,
  // index edges, spare command codes and a clear.
  task automatic run_directed();
    issue(mk(CMD_INSERT, 32'h0000_0001, 32'h0000_0001, IDX_NONE));
    issue(mk(CMD_INSERT, 32'h0000_0001, 32'h0000_0001, IDX_NONE));
    issue(mk(CMD_INSERT, 32'h0000_1001, 32'h0000_0007, IDX_NONE));
    issue(mk(CMD_INSERT, 32'h0000_0001, 32'h0000_0002, IDX_NONE));
    issue(mk(CMD_INSERT, 32'h7fff_ffff, 32'hffff_ffff, IDX_NONE));
    issue(mk(CMD_INSERT, 32'h8000_0000, 32'h0000_0001, IDX_NONE));
    issue(mk(CMD_INSERT, 32'h0000_0000, 32'h0000_0005, IDX_NONE));
    issue(mk(CMD_INSERT, TAG_NONE, 32'h0000_0005, IDX_NONE));
    issue(mk(CMD_INSERT, 32'h0000_0005, 32'h0000_0000, IDX_NONE));
    issue(mk(CMD_CHECK, 32'h0000_0001, 32'h0000_0002, IDX_NONE));
    issue(mk(CMD_CHECK, 32'h0000_0001, 32'h0000_0003, IDX_NONE));
    issue(mk(CMD_CHECK, 32'h0000_0000, 32'h0000_0001, IDX_NONE));
    issue(mk(CMD_FIND_FIRST, 32'h0000_0001, '0, IDX_NONE));
    issue(mk(CMD_FIND_NEXT, 32'h0000_0001, '0, 11'd0));
    issue(mk(CMD_FIND_NEXT, 32'h0000_0001, '0, 11'd2));
    issue(mk(CMD_FIND_NEXT, 32'h0000_0001, '0, IDX_NONE));
    issue(mk(CMD_FIND_NEXT, 32'h0000_0001, '0, 11'd1023));
    issue(mk(CMD_FIND_NEXT, TAG_NONE, '0, 11'd0));
    issue(mk(CMD_FIND_NEXT, 32'h0000_0001, '0, 11'h400));
    issue(mk(CMD_READ, '0, '0, 11'd0));
    issue(mk(CMD_READ, '0, '0, IDX_NONE));
    issue(mk(CMD_READ, '0, '0, IDX_W'(shadow.fill)));
    issue(mk(CMD_SPARE_A, 32'h0000_0001, 32'h0000_0001, 11'd0));
    issue(mk(CMD_SPARE_B, 32'h0000_0001, 32'h0000_0001, 11'd0));
    issue(mk(CMD_CLEAR, '0, '0, IDX_NONE));
    issue(mk(CMD_READ, '0, '0, 11'd0));
    issue(mk(CMD_FIND_FIRST, 32'h0000_0001, '0, IDX_NONE));
  endtask

  // Main sequence: reset, directed part, mixed phase, fill to capacity.
  initial begin : stimulus
    int n;
    rst_ni         <= 1'b0;
    cmd_if.valid   <= 1'b0;
    cmd_if.command <= CMD_INSERT;
    cmd_if.tag     <= '0;
    cmd_if.value   <= '0;
    cmd_if.index   <= IDX_NONE;
    chase_tag = '0;
    chase_idx = IDX_NONE;
    foreach (bucket_pool[k]) bucket_pool[k] = BKT_W'($urandom());
    bucket_pool[1] = '0;
    bucket_pool[2] = BKT_LAST;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    run_directed();
    pause_until_drained();

    for (n = 0; n < MIXED_ITEMS; n++) issue(mixed_command(1'b1));
    pause_until_drained();

    // Start the fill from an empty table and keep going until it is full.
    issue(mk(CMD_CLEAR, '0, '0, IDX_NONE));
    while (shadow.fill < CAPACITY) issue(fill_command());
    for (n = 0; n < TAIL_ITEMS; n++) issue(mixed_command(1'b0));

    pause_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Run covered %0d commands and %0d answers: %0d entries stored, %0d clears,",
             shadow.commands_seen, shadow.answers_seen, shadow.stored, shadow.clears);
    $display("%0d rejected, %0d refused on a full store, longest chain walk %0d entries.",
             shadow.rejects, shadow.full_hits, shadow.deepest_walk);
    if (shadow.mismatches == 0) begin
      $display("chained_tag_hash_multimap test passed");
    end else begin
      $display("chained_tag_hash_multimap test failed");
    end
    $finish;
  end

endmodule
